[design/montgomery_modular_reduction_macros.svh]
// Assertion macros for the modular reduction block.
`ifndef MONTGOMERY_MODULAR_REDUCTION_MACROS_SVH
`define MONTGOMERY_MODULAR_REDUCTION_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define MMR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define MMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mmr_pkg.sv]
// Package for the modular reduction block: codes, defaults and types.
package mmr_pkg;

    localparam int IN_WIDTH_DEF    = 16;
    localparam int MOD_WIDTH_DEF   = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int MODULUS_RESET   = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODE    = 2'd1;

    // Result error codes
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_EVEN_MOD = 2'd1,
        ERR_TOO_WIDE = 2'd2
    } err_t;

endpackage

[design/montgomery_modular_reduction.sv]
// Pipelined modular reduction, plain X mod M or Montgomery X*R^-1 mod M.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  command  | start / busy           | operand
//  result   | done (one-cycle pulse) | residue, error_code
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One operand enters per cycle; busy stays low.
// Each stage handles one restoring-division bit, then one Montgomery halving
// step per stage follows (passed through in plain mode).
// Reset clears the stage valid bits and loads modulus 3, mode 0.
// The result side cannot stall, so the pipeline never holds.
`include "montgomery_modular_reduction_macros.svh"

module montgomery_modular_reduction #(
    parameter int IN_WIDTH  = mmr_pkg::IN_WIDTH_DEF,
    parameter int MOD_WIDTH = mmr_pkg::MOD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [IN_WIDTH-1:0]                 operand,
    // result channel
    output logic                                done,
    output logic [MOD_WIDTH-1:0]                residue,
    output logic [1:0]                          error_code,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mmr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [MOD_WIDTH-1:0]                cfg_data
);

    localparam int NSTAGE = IN_WIDTH + MOD_WIDTH;

    logic [MOD_WIDTH-1:0] modulus_reg;
    logic                 mode_reg;

    logic                 vld_reg [NSTAGE];
    logic [MOD_WIDTH-1:0] rem_reg [NSTAGE];
    mmr_pkg::err_t        err_reg [NSTAGE];
    logic [IN_WIDTH-1:0]  x_reg   [IN_WIDTH-1];

    logic [MOD_WIDTH-1:0] step_en;
    logic [IN_WIDTH-1:0]  bit_fits;
    logic                 too_wide;
    mmr_pkg::err_t        entry_err;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_WIDTH'(mmr_pkg::MODULUS_RESET);
            mode_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mmr_pkg::CFG_MODULUS: modulus_reg <= cfg_data;
                mmr_pkg::CFG_MODE:    mode_reg    <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // Montgomery step i runs iff i is below the modulus bit length
    always_comb
    begin
        for (int i = 0; i < MOD_WIDTH; i++)
        begin
            step_en[i] = |(modulus_reg >> i);
        end
    end

    // Operand bit j fits in 2*B bits iff j/2 is below the bit length
    genvar j;
    generate
        for (j = 0; j < IN_WIDTH; j++)
        begin : g_fit
            if ((j >> 1) < MOD_WIDTH)
            begin : g_in
                assign bit_fits[j] = step_en[j >> 1];
            end
            else
            begin : g_out
                assign bit_fits[j] = 1'b0;
            end
        end
    endgenerate

    assign too_wide = |(operand & ~bit_fits);

    // Classify the operand on entry; even modulus wins
    always_comb
    begin
        if (!modulus_reg[0])
        begin
            entry_err = mmr_pkg::ERR_EVEN_MOD;
        end
        else if (mode_reg && too_wide)
        begin
            entry_err = mmr_pkg::ERR_TOO_WIDE;
        end
        else
        begin
            entry_err = mmr_pkg::ERR_NONE;
        end
    end

    // Pipeline stages
    genvar s;
    generate
        for (s = 0; s < NSTAGE; s++)
        begin : g_stage
            logic                 v_in;
            logic [MOD_WIDTH-1:0] r_in;
            mmr_pkg::err_t        e_in;
            logic [MOD_WIDTH-1:0] r_out;

            if (s == 0)
            begin : g_src_port
                assign v_in = start && !busy;
                assign r_in = '0;
                assign e_in = entry_err;
            end
            else
            begin : g_src_reg
                assign v_in = vld_reg[s-1];
                assign r_in = rem_reg[s-1];
                assign e_in = err_reg[s-1];
            end

            if (s < IN_WIDTH)
            begin : g_div
                logic [IN_WIDTH-1:0]  x_in;
                logic [MOD_WIDTH:0]   shifted;
                logic [MOD_WIDTH:0]   diff;

                if (s == 0)
                begin : g_x_port
                    assign x_in = operand;
                end
                else
                begin : g_x_reg
                    assign x_in = x_reg[s-1];
                end

                // Shift in the next operand bit, subtract M when it fits
                assign shifted = {r_in, x_in[IN_WIDTH-1-s]};
                assign diff    = shifted - {1'b0, modulus_reg};
                assign r_out   = (shifted >= {1'b0, modulus_reg}) ?
                                 diff[MOD_WIDTH-1:0] : shifted[MOD_WIDTH-1:0];

                if (s < IN_WIDTH - 1)
                begin : g_x_fwd
                    always_ff @(posedge clk)
                    begin
                        x_reg[s] <= x_in;
                    end
                end
            end
            else
            begin : g_mont
                logic [MOD_WIDTH:0] sum;

                // Add M when odd, then halve
                assign sum   = {1'b0, r_in} + (r_in[0] ? {1'b0, modulus_reg} : '0);
                assign r_out = (mode_reg && step_en[s-IN_WIDTH]) ?
                               sum[MOD_WIDTH:1] : r_in;
            end

            // Advance the valid bit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else
                begin
                    vld_reg[s] <= v_in;
                end
            end

            // Advance the payload
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= r_out;
                err_reg[s] <= e_in;
            end
        end
    endgenerate

    // Drive the result beat; errors force a zero residue
    assign done       = vld_reg[NSTAGE-1];
    assign error_code = err_reg[NSTAGE-1];
    assign residue    = (err_reg[NSTAGE-1] == mmr_pkg::ERR_NONE) ? rem_reg[NSTAGE-1] : '0;

    `MMR_ASSERT_NOW(a_err_zero, done && (error_code != mmr_pkg::ERR_NONE), residue == '0, "error result with nonzero residue")
    `MMR_ASSERT_NOW(a_res_range, done && (error_code == mmr_pkg::ERR_NONE), residue < modulus_reg, "residue not fully reduced")
    `MMR_ASSERT_NOW(a_even_flag, done && (error_code == mmr_pkg::ERR_EVEN_MOD), !modulus_reg[0], "even-modulus flag with odd modulus")
    `MMR_ASSERT_NOW(a_wide_mode, done && (error_code == mmr_pkg::ERR_TOO_WIDE), mode_reg && modulus_reg[0], "width error outside Montgomery mode")
    `MMR_ASSERT_NEXT(a_cfg_mode, cfg_valid && cfg_ready && (cfg_index == mmr_pkg::CFG_MODE), mode_reg == $past(cfg_data[0]), "mode write lost")

endmodule
